// File: rtl/sszc_pkg.sv
// shared types and constants for the sample statistics unit
package sszc_pkg;

    localparam int CNT_OUT_W  = 8;
    localparam int MEAN_W     = 24;
    localparam int VAR_W      = 39;
    localparam int SD_W       = 24;
    localparam int XING_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int MARKER_W   = 16;
    localparam int MAXS_W     = 8;

    localparam logic [STATUS_W-1:0] STATUS_VALID  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SINGLE = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_END_MARKER  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SAMPLES = 2'd1;

    localparam logic [MARKER_W-1:0] END_MARKER_RESET  = 16'd9999;
    localparam logic [MAXS_W-1:0]   MAX_SAMPLES_RESET = 8'd100;
    localparam logic [XING_W-1:0]   XING_MAX          = 7'd127;

    typedef struct packed {
        logic accept;
        logic mul;
        logic mean_start;
        logic mean_cap;
        logic var_start;
        logic var_cap;
        logic sqrt_start;
        logic load_out;
    } sszc_cmd_t;

    typedef struct packed {
        logic close;
        logic n_zero;
        logic n_one;
        logic div_done;
        logic sqrt_done;
    } sszc_stat_t;

endpackage

// File: rtl/sszc_div.sv
// restoring divider, one quotient bit per cycle
module sszc_div #(
    parameter int DIVIDEND_W = 64,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);
    localparam int CTW = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CTW-1:0]        cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  ge;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_diff = rem_sh - {1'b0, dvs_reg};
        ge       = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CTW'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

// File: rtl/sszc_sqrt.sv
// digit by digit integer square root, one root bit per cycle
module sszc_sqrt #(
    parameter int RAD_W = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [RAD_W-1:0]   radicand,
    output logic [RAD_W/2-1:0] root,
    output logic               done
);
    localparam int RT  = RAD_W / 2;
    localparam int CTW = (RT > 1) ? $clog2(RT) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CTW-1:0]   cnt_reg, cnt_next;
    logic [RAD_W-1:0] rad_reg, rad_next;
    logic [RT-1:0]    root_reg, root_next;
    logic [RT+1:0]    rem_reg, rem_next;
    logic [RT+3:0]    rem_sh;
    logic [RT+3:0]    trial;
    logic [RT+3:0]    rem_diff;
    logic             ge;

    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial    = (RT+4)'({root_reg, 2'b01});
        rem_diff = rem_sh - trial;
        ge       = rem_sh >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            root_next = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_diff[RT+1:0] : rem_sh[RT+1:0];
            root_next = {root_reg[RT-2:0], ge};
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CTW'(RT - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign root = root_reg;
    assign done = done_reg;
endmodule

// File: rtl/sszc_datapath.sv
// accumulators, config registers, final arithmetic and result register
module sszc_datapath #(
    parameter int MAX_COUNT   = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sszc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sszc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic signed [15:0]                  sample,
    input  sszc_pkg::sszc_cmd_t                 cmd,
    output sszc_pkg::sszc_stat_t                stat,
    output logic [sszc_pkg::CNT_OUT_W-1:0]      sample_count,
    output logic signed [sszc_pkg::MEAN_W-1:0]  mean_q8,
    output logic [sszc_pkg::VAR_W-1:0]          variance_q8,
    output logic [sszc_pkg::SD_W-1:0]           std_dev_q8,
    output logic [sszc_pkg::XING_W-1:0]         sign_changes,
    output logic                                hit_capacity,
    output logic [sszc_pkg::STATUS_W-1:0]       status
);
    import sszc_pkg::*;

    localparam int CW   = $clog2(MAX_COUNT + 1);
    localparam int SUMW = SAMPLE_BITS + CW;
    localparam int SQW  = 2 * SAMPLE_BITS + CW;
    localparam int DW   = SQW + CW;
    localparam int QW   = DW + 16;
    localparam int DVW  = 2 * CW;
    localparam int RW   = QW + (QW % 2);
    localparam int CAPW = (CW > MAXS_W) ? CW : MAXS_W;
    localparam int MQW  = SUMW + 9;
    localparam int MEXT = (MQW > MEAN_W) ? MQW : MEAN_W;
    localparam int VQW  = QW - 8;
    localparam int VEXT = (VQW > VAR_W) ? VQW : VAR_W;
    localparam int SEXT = (RW / 2 > SD_W) ? RW / 2 : SD_W;
    localparam int NEXT = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

    // configuration
    logic [MARKER_W-1:0] end_marker_reg;
    logic [MAXS_W-1:0]   max_samples_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_marker_reg  <= END_MARKER_RESET;
            max_samples_reg <= MAX_SAMPLES_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_addr == REG_END_MARKER)
                end_marker_reg <= cfg_wdata[MARKER_W-1:0];
            else if (cfg_addr == REG_MAX_SAMPLES)
                max_samples_reg <= cfg_wdata[MAXS_W-1:0];
        end
    end

    // running accumulators
    logic [CW-1:0]                 count_reg;
    logic signed [SUMW-1:0]        sum_reg;
    logic [SQW-1:0]                sumsq_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic [XING_W-1:0]             xing_reg;

    logic signed [SAMPLE_BITS-1:0]   x;
    logic signed [SAMPLE_BITS-1:0]   mark;
    logic signed [2*SAMPLE_BITS-1:0] sq_s;
    logic [CAPW-1:0]                 ms_ext;
    logic [CAPW-1:0]                 cap_ext;
    logic [CW-1:0]                   count_inc;
    logic signed [SUMW-1:0]          sum_new;
    logic [SQW-1:0]                  sumsq_new;
    logic [XING_W-1:0]               xing_new;
    logic                            is_mark;
    logic                            hit;
    logic                            change;

    always_comb
    begin
        x         = sample[SAMPLE_BITS-1:0];
        mark      = end_marker_reg[SAMPLE_BITS-1:0];
        is_mark   = x == mark;
        ms_ext    = CAPW'(max_samples_reg);
        cap_ext   = (ms_ext == '0 || ms_ext > CAPW'(MAX_COUNT)) ? CAPW'(MAX_COUNT) : ms_ext;
        count_inc = count_reg + 1'b1;
        hit       = !is_mark && (CAPW'(count_inc) >= cap_ext);
        sq_s      = x * x;
        sum_new   = sum_reg + SUMW'(x);
        sumsq_new = sumsq_reg + SQW'(unsigned'(sq_s));
        change    = (prev_reg < 0 && x > 0) || (prev_reg > 0 && x < 0);
        xing_new  = xing_reg;
        if (count_reg != '0 && change && xing_reg != XING_MAX)
            xing_new = xing_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            prev_reg  <= '0;
            xing_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            if (is_mark || hit)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                sumsq_reg <= '0;
                prev_reg  <= '0;
                xing_reg  <= '0;
            end
            else
            begin
                count_reg <= count_inc;
                sum_reg   <= sum_new;
                sumsq_reg <= sumsq_new;
                prev_reg  <= x;
                xing_reg  <= xing_new;
            end
        end
    end

    // snapshot of the closed sequence
    logic [CW-1:0]          snap_n;
    logic signed [SUMW-1:0] snap_sum;
    logic [SQW-1:0]         snap_sq;
    logic [XING_W-1:0]      snap_xing;
    logic                   snap_hit;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (is_mark || hit))
        begin
            snap_n    <= is_mark ? count_reg : count_inc;
            snap_sum  <= is_mark ? sum_reg : sum_new;
            snap_sq   <= is_mark ? sumsq_reg : sumsq_new;
            snap_xing <= is_mark ? xing_reg : xing_new;
            snap_hit  <= hit;
        end
    end

    logic [SUMW-1:0] mag;
    assign mag = (snap_sum < 0) ? SUMW'(-snap_sum) : SUMW'(snap_sum);

    // products for the variance numerator
    logic [DW-1:0]  prod_a_reg;
    logic [DW-1:0]  prod_b_reg;
    logic [DVW-1:0] den_reg;
    logic [DW-1:0]  d_num;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_a_reg <= DW'(snap_n) * DW'(snap_sq);
            prod_b_reg <= DW'(mag) * DW'(mag);
            den_reg    <= DVW'(snap_n) * DVW'(snap_n - 1'b1);
        end
    end

    assign d_num = prod_a_reg - prod_b_reg;

    // shared divider: mean first, then scaled variance
    logic [QW-1:0]  div_dividend;
    logic [DVW-1:0] div_divisor;
    logic [QW-1:0]  div_quotient;
    logic           div_done;

    assign div_dividend = cmd.mean_start ? QW'({mag, 8'b0}) : {d_num, 16'b0};
    assign div_divisor  = cmd.mean_start ? DVW'(snap_n) : den_reg;

    sszc_div #(
        .DIVIDEND_W(QW),
        .DIVISOR_W (DVW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mean_start || cmd.var_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .quotient(div_quotient),
        .done    (div_done)
    );

    logic [RW/2-1:0] sd_root;
    logic            sqrt_done;

    sszc_sqrt #(
        .RAD_W(RW)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sqrt_start),
        .radicand(RW'(div_quotient)),
        .root    (sd_root),
        .done    (sqrt_done)
    );

    logic signed [MQW-1:0] mean_reg;
    logic [QW-1:0]         q_reg;
    logic signed [MQW-1:0] mean_mag;

    assign mean_mag = signed'({1'b0, div_quotient[SUMW+7:0]});

    always_ff @(posedge clk)
    begin
        if (cmd.mean_cap)
            mean_reg <= (snap_sum < 0) ? -mean_mag : mean_mag;
        if (cmd.var_cap)
            q_reg <= div_quotient;
    end

    // result register
    logic signed [MEXT-1:0] mean_full;
    logic [VEXT-1:0]        var_full;
    logic [SEXT-1:0]        sd_full;
    logic [NEXT-1:0]        n_full;
    logic                   n_zero;
    logic                   n_one;

    assign n_zero    = snap_n == '0;
    assign n_one     = snap_n == CW'(1);
    assign mean_full = MEXT'(mean_reg);
    assign var_full  = VEXT'(q_reg[QW-1:8]);
    assign sd_full   = SEXT'(sd_root);
    assign n_full    = NEXT'(snap_n);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sample_count <= n_full[CNT_OUT_W-1:0];
            sign_changes <= snap_xing;
            hit_capacity <= snap_hit;
            mean_q8      <= n_zero ? '0 : mean_full[MEAN_W-1:0];
            variance_q8  <= (n_zero || n_one) ? '0 : var_full[VAR_W-1:0];
            std_dev_q8   <= (n_zero || n_one) ? '0 : sd_full[SD_W-1:0];
            status       <= n_zero ? STATUS_EMPTY : (n_one ? STATUS_SINGLE : STATUS_VALID);
        end
    end

    always_comb
    begin
        stat.close     = is_mark || hit;
        stat.n_zero    = n_zero;
        stat.n_one     = n_one;
        stat.div_done  = div_done;
        stat.sqrt_done = sqrt_done;
    end

    // a closing word always leaves the accumulators cleared
    a_clear_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && (is_mark || hit)) |=> (count_reg == '0 && xing_reg == '0))
        else $error("accumulators not cleared after close");

    // the count never runs past the capacity ceiling
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CAPW'(count_reg) < CAPW'(MAX_COUNT))
        else $error("sample count beyond capacity");

    // a capacity close always carries at least one sample
    a_hit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && hit) |=> snap_n != '0)
        else $error("capacity close with empty snapshot");
endmodule

// File: rtl/sszc_ctrl.sv
// sequencing of accumulate, multiply, divide, square root and result hand-off
module sszc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  sszc_pkg::sszc_stat_t stat,
    output sszc_pkg::sszc_cmd_t  cmd
);
    import sszc_pkg::*;

    localparam logic [2:0] S_ACC  = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_MDIV = 3'd2;
    localparam logic [2:0] S_VDIV = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_ACC:
            begin
                cmd.accept = in_valid;
                if (in_valid && stat.close)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.n_zero)
                    state_next = S_OUT;
                else
                begin
                    cmd.mean_start = 1'b1;
                    state_next     = S_MDIV;
                end
            end
            S_MDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_cap = 1'b1;
                    if (stat.n_one)
                        state_next = S_OUT;
                    else
                    begin
                        cmd.var_start = 1'b1;
                        state_next    = S_VDIV;
                    end
                end
            end
            S_VDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.var_cap    = 1'b1;
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (stat.sqrt_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
        out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_ACC;
    assign out_valid = out_valid_reg;
endmodule

// File: rtl/sample_statistics_with_zero_crossings_unit.sv
// top level of the sample statistics and sign-change unit
// accumulation: one word per cycle while in_ready is high, a count, sum and square-sum update
// closing word: a multiply, bit-serial mean and variance divides over QW bits, then the root;
//   QW = 2*SAMPLE_BITS + 2*clog2(MAX_COUNT+1) + 16; under two samples skip the later steps
// no input word is taken until the result is loaded; input resumes the cycle it turns valid
// reset (async, active low) clears accumulators, restores end marker 9999 and capacity 100
module sample_statistics_with_zero_crossings_unit #(
    parameter int MAX_COUNT   = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sszc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sszc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [15:0]                  sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sszc_pkg::CNT_OUT_W-1:0]      sample_count,
    output logic signed [sszc_pkg::MEAN_W-1:0]  mean_q8,
    output logic [sszc_pkg::VAR_W-1:0]          variance_q8,
    output logic [sszc_pkg::SD_W-1:0]           std_dev_q8,
    output logic [sszc_pkg::XING_W-1:0]         sign_changes,
    output logic                                hit_capacity,
    output logic [sszc_pkg::STATUS_W-1:0]       status
);
    import sszc_pkg::*;

    sszc_cmd_t  cmd;
    sszc_stat_t stat;

    sszc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sszc_datapath #(
        .MAX_COUNT  (MAX_COUNT),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .sample      (sample),
        .cmd         (cmd),
        .stat        (stat),
        .sample_count(sample_count),
        .mean_q8     (mean_q8),
        .variance_q8 (variance_q8),
        .std_dev_q8  (std_dev_q8),
        .sign_changes(sign_changes),
        .hit_capacity(hit_capacity),
        .status      (status)
    );

    // an empty sequence reports zeros throughout
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_EMPTY) |->
        (sample_count == '0 && mean_q8 == '0 && variance_q8 == '0 && sign_changes == '0))
        else $error("empty result with nonzero fields");

    // a single-sample result carries no spread
    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_SINGLE) |-> (variance_q8 == '0 && std_dev_q8 == '0))
        else $error("single sample result with nonzero spread");

    // input is never taken while the closed sequence is being worked out
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && stat.close) |=> !in_ready)
        else $error("input taken during result computation");
endmodule
